[rtl/core/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg: shared definitions for the character LCD line refresh block
// Command codes, frame header bytes and the controller state encoding.
// ----------------------------------------------------------------------------
package clr_pkg;

	localparam logic       CMD_PLACE = 1'b0;
	localparam logic       CMD_CLEAR = 1'b1;

	localparam logic [7:0] SPACE_CHAR     = 8'h20;
	localparam logic [7:0] DEV_ADDR_RESET = 8'h7C;
	localparam logic [7:0] CTRL_CMD_BYTE  = 8'h80;
	localparam logic [7:0] DDRAM_ROW0     = 8'h80;
	localparam logic [7:0] DDRAM_ROW1     = 8'hC0;
	localparam logic [7:0] CTRL_DATA_BYTE = 8'h40;

	// Number of header bytes ahead of the row characters in every frame.
	localparam int HDR_LEN = 4;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} clr_state_t;

endpackage

[rtl/core/char_lcd_line_refresh.sv]
// ----------------------------------------------------------------------------
// char_lcd_line_refresh: two-row character LCD line store with frame output
// Stores string characters into a 2 x ROW_LENGTH line memory and emits I2C
// frame bytes for a row when a string ends, or for both rows on a clear.
// ----------------------------------------------------------------------------
// A place command without last_char is taken while busy stays low.
// A place command with last_char, or a clear, raises busy and emits one frame
// (clear: two) of ROW_LENGTH + 4 beats, one beat per cycle on strobe; the
// first beat leaves once state_q has entered ST_EMIT and the output stage has
// registered it. busy falls once the last line memory read is issued, so the
// next item can be taken while the final beat leaves. The figure is set by the
// single read port of the line memory, which delivers one stored character per
// cycle. Results cannot be stalled: the receiver must take a beat in every
// cycle that strobe is high. Reset and clear restore all characters to spaces
// at once through per-entry valid bits, so no clearing pass is needed.
module char_lcd_line_refresh
	import clr_pkg::*;
#(
	parameter int ROW_LENGTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_write,
	input  logic [7:0] cfg_data,
	// command channel
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic       row,
	input  logic [3:0] start_column,
	input  logic       centre,
	input  logic [7:0] string_length,
	input  logic [7:0] char_code,
	input  logic       last_char,
	// result channel
	output logic       strobe,
	output logic [7:0] frame_byte,
	output logic       frame_start,
	output logic       frame_end,
	output logic       run_last
);

	localparam int DEPTH     = 2 * ROW_LENGTH;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int COL_W     = $clog2(ROW_LENGTH);
	localparam int FRAME_LEN = ROW_LENGTH + HDR_LEN;
	localparam int K_W       = $clog2(FRAME_LEN);

	clr_state_t          state_q;
	logic [7:0]          dev_addr_q;
	logic [7:0]          char_pos_q;
	logic [K_W-1:0]      k_q;
	logic                frame_row_q;
	logic                second_q;
	logic [DEPTH-1:0]    valid_q;

	logic [7:0]          mem [DEPTH];
	logic [7:0]          mem_rd_s1;

	logic                hdr_sel_s1;
	logic [7:0]          hdr_s1;
	logic                vld_s1;
	logic                strobe_s1;
	logic                first_s1;
	logic                end_s1;
	logic                last_s1;

	logic                accept;
	logic                place_acc;
	logic [8:0]          start_col;
	logic [8:0]          col;
	logic                col_ok;
	logic                mem_we;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [K_W-1:0]      k_char;
	logic                k_is_hdr;
	logic                k_is_end;
	logic [7:0]          hdr_byte;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign place_acc = accept && (command == CMD_PLACE);

	// Column of this character; centring uses (ROW_LENGTH - len) / 2, or 0 when len is not below ROW_LENGTH.
	always_comb begin
		if (centre) begin
			if (string_length < 8'(ROW_LENGTH))
				start_col = 9'((8'(ROW_LENGTH) - string_length) >> 1);
			else
				start_col = '0;
		end else begin
			start_col = {5'd0, start_column};
		end
		col    = start_col + {1'b0, char_pos_q};
		col_ok = (char_pos_q < string_length) && (col < 9'(ROW_LENGTH));
	end

	assign mem_we  = place_acc && col_ok;
	assign wr_addr = (row ? ADDR_W'(ROW_LENGTH) : '0) + ADDR_W'(col[COL_W-1:0]);

	assign k_char   = k_q - K_W'(HDR_LEN);
	assign rd_addr  = (frame_row_q ? ADDR_W'(ROW_LENGTH) : '0) + ADDR_W'(k_char);
	assign k_is_hdr = (k_q < K_W'(HDR_LEN));
	assign k_is_end = (k_q == K_W'(FRAME_LEN - 1));

	always_comb begin
		case (k_q)
			K_W'(0): hdr_byte = dev_addr_q;
			K_W'(1): hdr_byte = CTRL_CMD_BYTE;
			K_W'(2): hdr_byte = frame_row_q ? DDRAM_ROW1 : DDRAM_ROW0;
			K_W'(3): hdr_byte = CTRL_DATA_BYTE;
			default: hdr_byte = CTRL_DATA_BYTE;
		endcase
	end

	// Line memory: one write port for placement, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= char_code;
		mem_rd_s1 <= mem[rd_addr];
	end

	// An entry that is not valid reads as a space.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && (command == CMD_CLEAR)) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_write) begin
			dev_addr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			char_pos_q  <= '0;
			k_q         <= '0;
			frame_row_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_CLEAR) begin
							char_pos_q  <= '0;
							k_q         <= '0;
							frame_row_q <= 1'b0;
							second_q    <= 1'b1;
							state_q     <= ST_EMIT;
						end else if (last_char) begin
							char_pos_q  <= '0;
							k_q         <= '0;
							frame_row_q <= row;
							second_q    <= 1'b0;
							state_q     <= ST_EMIT;
						end else if (char_pos_q != 8'hFF) begin
							char_pos_q <= char_pos_q + 8'd1;
						end
					end
				end
				ST_EMIT: begin
					if (k_is_end) begin
						k_q <= '0;
						if (second_q) begin
							second_q    <= 1'b0;
							frame_row_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output stage, aligned with the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		hdr_sel_s1 <= k_is_hdr;
		hdr_s1     <= hdr_byte;
		vld_s1     <= valid_q[rd_addr];
		first_s1   <= (k_q == '0);
		end_s1     <= k_is_end;
		last_s1    <= k_is_end && !second_q;
	end

	assign strobe      = strobe_s1;
	assign frame_byte  = hdr_sel_s1 ? hdr_s1 : (vld_s1 ? mem_rd_s1 : SPACE_CHAR);
	assign frame_start = first_s1;
	assign frame_end   = end_s1;
	assign run_last    = last_s1;

endmodule

[rtl/core/clr_checker.sv]
// ----------------------------------------------------------------------------
// clr_checker: port-level checks for the character LCD line refresh block
// Watches the command and result ports over time; attached by bind.
// ----------------------------------------------------------------------------
module clr_checker
	import clr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       command,
	input logic       last_char,
	input logic       strobe,
	input logic [7:0] frame_byte,
	input logic       frame_start,
	input logic       frame_end,
	input logic       run_last
);

	// A character that does not end its string is stored without output.
	a_place_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == CMD_PLACE) && !last_char |=> !busy && !strobe)
		else $error("place without last_char raised busy or strobe");

	// The second beat of every frame is the control command byte.
	a_second_byte: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_start |=> strobe && !frame_start && (frame_byte == CTRL_CMD_BYTE))
		else $error("frame header second byte wrong");

	// The final beat of an item always closes a frame.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && run_last |-> frame_end)
		else $error("run_last without frame_end");

	// A frame that is not the final one of a clear is followed by the next frame.
	a_next_frame: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_end && !run_last |=> strobe && frame_start)
		else $error("second frame of clear did not follow");

	// A frame request keeps the command side busy in the next cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((command == CMD_CLEAR) || last_char) |=> busy)
		else $error("frame request did not raise busy");

endmodule

bind char_lcd_line_refresh clr_checker u_clr_checker (.*);

[dv/char_lcd_line_refresh_tb.sv]
// ----------------------------------------------------------------------------
// char_lcd_line_refresh_tb: self-checking bench for the LCD line refresh block
// Drives place and clear commands through the start/busy handshake. A shadow
// copy of both display rows predicts every frame byte, and each strobed beat
// is checked against the oldest predicted beat.
// ----------------------------------------------------------------------------
module char_lcd_line_refresh_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import clr_pkg::*;

	localparam int ROW_LENGTH = 16;
	localparam int FRAME_LEN  = ROW_LENGTH + HDR_LEN;
	localparam int POS_MAX    = 255;
	localparam int SETTLE     = 8;
	localparam int LIMIT      = 400000;
	localparam int RANDOM_ITEMS = 24;
	localparam int PHASES     = 4;
	localparam int STRING_CAP = 12;

	typedef struct packed {
		logic [7:0] data;
		logic       opens;
		logic       closes;
		logic       ends_run;
	} frame_beat_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       cfg_write     = 1'b0;
	logic [7:0] cfg_data      = '0;
	logic       start         = 1'b0;
	logic       busy;
	logic       command       = CMD_PLACE;
	logic       row           = 1'b0;
	logic [3:0] start_column  = '0;
	logic       centre        = 1'b0;
	logic [7:0] string_length = '0;
	logic [7:0] char_code     = '0;
	logic       last_char     = 1'b0;
	logic       strobe;
	logic [7:0] frame_byte;
	logic       frame_start;
	logic       frame_end;
	logic       run_last;

	// Shadow of the display rows and of the string position counter.
	logic [7:0]  row_text [0:1][0:ROW_LENGTH-1];
	int unsigned char_pos;
	logic [7:0]  addr_byte;

	frame_beat_t frame_bytes_due [$];
	int          errors      = 0;
	int          cycle_count = 0;
	int          items_sent  = 0;
	logic        gaps_on     = 1'b1;

	char_lcd_line_refresh #(
		.ROW_LENGTH(ROW_LENGTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.row          (row),
		.start_column (start_column),
		.centre       (centre),
		.string_length(string_length),
		.char_code    (char_code),
		.last_char    (last_char),
		.strobe       (strobe),
		.frame_byte   (frame_byte),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("char_lcd_line_refresh: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin : check_beat
		frame_beat_t want;
		frame_beat_t got;
		if (arst_n && strobe) begin
			got = '{frame_byte, frame_start, frame_end, run_last};
			if (frame_bytes_due.size() == 0) begin
				errors++;
				$display("%0t: beat with nothing expected, got byte %h start %b end %b last %b",
					$time, frame_byte, frame_start, frame_end, run_last);
			end else begin
				want = frame_bytes_due.pop_front();
				if (got != want) begin
					errors++;
					$display({"%0t: expected byte %h start %b end %b last %b, ",
						"got byte %h start %b end %b last %b"},
						$time, want.data, want.opens, want.closes, want.ends_run,
						got.data, got.opens, got.closes, got.ends_run);
				end
			end
		end
	end

	function automatic void blank_rows();
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < ROW_LENGTH; c++)
				row_text[r][c] = SPACE_CHAR;
	endfunction

	function automatic void queue_row_frame(input logic sel, input logic ends_run);
		frame_beat_t b;
		for (int k = 0; k < FRAME_LEN; k++) begin
			case (k)
				0: b.data = addr_byte;
				1: b.data = CTRL_CMD_BYTE;
				2: b.data = sel ? DDRAM_ROW1 : DDRAM_ROW0;
				3: b.data = CTRL_DATA_BYTE;
				default: b.data = row_text[sel][k-HDR_LEN];
			endcase
			b.opens    = (k == 0);
			b.closes   = (k == FRAME_LEN - 1);
			b.ends_run = ends_run && b.closes;
			frame_bytes_due.push_back(b);
		end
	endfunction

	function automatic void apply_command(input logic cmd, input logic sel,
			input logic [3:0] col, input logic ctr, input logic [7:0] len,
			input logic [7:0] ch, input logic fin);
		int first_col;
		int col_at;
		if (cmd == CMD_CLEAR) begin
			blank_rows();
			char_pos = 0;
			queue_row_frame(1'b0, 1'b0);
			queue_row_frame(1'b1, 1'b1);
		end else begin
			if (ctr)
				first_col = (len < ROW_LENGTH) ? (ROW_LENGTH - int'(len)) / 2 : 0;
			else
				first_col = int'(col);
			col_at = first_col + int'(char_pos);
			// Characters past the string or past the row end are dropped.
			if (char_pos < len && col_at < ROW_LENGTH)
				row_text[sel][col_at] = ch;
			if (char_pos < POS_MAX)
				char_pos++;
			if (fin) begin
				char_pos = 0;
				queue_row_frame(sel, 1'b1);
			end
		end
	endfunction

	task automatic send_item(input logic cmd, input logic sel, input logic [3:0] col,
			input logic ctr, input logic [7:0] len, input logic [7:0] ch, input logic fin);
		if (gaps_on) begin
			while ($urandom_range(99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start         <= 1'b1;
		command       <= cmd;
		row           <= sel;
		start_column  <= col;
		centre        <= ctr;
		string_length <= len;
		char_code     <= ch;
		last_char     <= fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_command(cmd, sel, col, ctr, len, ch, fin);
		items_sent++;
	endtask

	task automatic send_string(input logic sel, input logic [3:0] col, input logic ctr,
			input logic [7:0] len, input int count);
		for (int i = 0; i < count; i++)
			send_item(CMD_PLACE, sel, col, ctr, len, 8'($urandom_range(255)),
				i == count - 1);
	endtask

	// Holds the sender off until every predicted beat has been seen.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (frame_bytes_due.size() != 0);
	endtask

	task automatic write_address(input logic [7:0] value);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		addr_byte = value;
	endtask

	// Empty refreshes straight after reset show two rows of spaces.
	task automatic test_reset_state();
		send_item(CMD_PLACE, 1'b0, 4'd0, 1'b0, 8'd0, 8'h41, 1'b1);
		send_item(CMD_PLACE, 1'b1, 4'd9, 1'b0, 8'd0, 8'h42, 1'b1);
	endtask

	task automatic test_placement();
		send_item(CMD_PLACE, 1'b0, 4'd0, 1'b0, 8'd3, 8'h00, 1'b0);
		send_item(CMD_PLACE, 1'b0, 4'd0, 1'b0, 8'd3, 8'hFF, 1'b0);
		send_item(CMD_PLACE, 1'b0, 4'd0, 1'b0, 8'd3, 8'h5A, 1'b1);
		send_item(CMD_PLACE, 1'b1, 4'd15, 1'b0, 8'd1, 8'hA5, 1'b1);
	endtask

	task automatic test_centring();
		send_item(CMD_PLACE, 1'b1, 4'd3, 1'b1, 8'd1, 8'h2A, 1'b1);
		send_string(1'b0, 4'd15, 1'b1, 8'd15, 2);
		send_item(CMD_PLACE, 1'b0, 4'd7, 1'b1, 8'd16, 8'h7E, 1'b1);
		send_item(CMD_PLACE, 1'b1, 4'd15, 1'b1, 8'd255, 8'h81, 1'b1);
	endtask

	task automatic test_overflow();
		// Two of these land past the end of the row.
		send_string(1'b0, 4'd14, 1'b0, 8'd4, 4);
		// The third character lies beyond the string length.
		send_string(1'b1, 4'd0, 1'b0, 8'd2, 3);
	endtask

	task automatic test_clear();
		send_item(CMD_CLEAR, 1'b1, 4'hF, 1'b1, 8'hFF, 8'hFF, 1'b1);
		send_item(CMD_CLEAR, 1'b0, 4'h0, 1'b0, 8'h00, 8'h00, 1'b0);
	endtask

	task automatic test_address();
		write_address(8'h00);
		send_item(CMD_PLACE, 1'b0, 4'd5, 1'b0, 8'd1, 8'h33, 1'b1);
		write_address(8'hFF);
		send_item(CMD_PLACE, 1'b1, 4'd0, 1'b0, 8'd0, 8'h00, 1'b1);
	endtask

	// A position counter that wrapped instead of holding at its top would
	// start overwriting the row from its first column. This long string is
	// also sent back to back with no sender gaps.
	task automatic test_counter_saturation();
		gaps_on = 1'b0;
		send_string(1'b0, 4'd0, 1'b0, 8'd255, 258);
		gaps_on = 1'b1;
	endtask

	task automatic test_random();
		int   phase_items;
		int   first_count;
		int   roll;
		int   count;
		logic [7:0] len;
		logic drained;
		drained = 1'b0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_address(8'hFF);
				2: write_address(8'h00);
				PHASES - 1: write_address(DEV_ADDR_RESET);
				default: write_address(8'($urandom_range(255)));
			endcase
			// One phase runs back to back with no sender gaps at all.
			gaps_on = (phase != 2);
			first_count = items_sent;
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / PHASES) begin
				if (phase == 3 && !drained && phase_items >= 3) begin
					drain();
					drained = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll < 6) begin
					send_item(CMD_CLEAR, 1'($urandom_range(1)), 4'($urandom_range(15)),
						1'($urandom_range(1)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 1'($urandom_range(1)));
				end else if (roll < 16) begin
					send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
						4'($urandom_range(15)), 1'($urandom_range(1)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
				end else begin
					len = ($urandom_range(99) < 80) ? 8'($urandom_range(18)) :
						8'($urandom_range(255));
					count = (len > STRING_CAP) ? STRING_CAP : int'(len);
					// Some strings end early or run past their stated length.
					if ($urandom_range(99) < 20)
						count = count + int'($urandom_range(4)) - 2;
					if (count < 1)
						count = 1;
					send_string(1'($urandom_range(1)), 4'($urandom_range(15)),
						1'($urandom_range(1)), len, count);
				end
				phase_items = items_sent - first_count;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		blank_rows();
		char_pos  = 0;
		addr_byte = DEV_ADDR_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_placement();
		test_centring();
		test_overflow();
		test_clear();
		test_address();
		test_counter_saturation();
		test_random();
		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("char_lcd_line_refresh: match");
		else
			$display("char_lcd_line_refresh: mismatch");
		$finish;
	end

endmodule
